// ----- src/bbc_pkg.sv -----
// types, constants and the control program of the bandpass filter cascade
// no dependencies; used by butterworth_bandpass_cascade
package bbc_pkg;

  localparam int HIST_W     = 40;
  localparam int HIST_FRAC  = 24;
  localparam int OPND_W     = HIST_W + 2;
  localparam int HALF_W     = OPND_W / 2;
  localparam int OPND_HALF_W = HALF_W + 1;
  localparam int ACC_W      = HIST_W + 7;
  localparam int PROD_W     = ACC_W;
  localparam int NSLOTS     = 5;
  localparam int SLOT_W     = 3;
  localparam int SECTION_W  = 2;
  localparam int PC_W       = 5;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_COEF   = 1'b1;

  localparam logic [SLOT_W-1:0] SLOT_GAIN = 3'd0;
  localparam logic [SLOT_W-1:0] SLOT_D1   = 3'd1;
  localparam logic [SLOT_W-1:0] SLOT_D2   = 3'd2;
  localparam logic [SLOT_W-1:0] SLOT_D3   = 3'd3;
  localparam logic [SLOT_W-1:0] SLOT_D4   = 3'd4;

  localparam logic [PC_W-1:0] STEP_TOP = 5'd0;

  typedef enum logic [2:0] {
    OPND_H1,
    OPND_H2,
    OPND_H3,
    OPND_H4,
    OPND_T
  } opnd_sel_t;

  typedef enum logic {
    HALF_LO,
    HALF_HI
  } half_t;

  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_LOADX,
    ACC_ADD
  } acc_op_t;

  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_LOOP,
    SEQ_END
  } seq_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    opnd_sel_t         opnd;
    half_t             half;
    acc_op_t           acc;
    logic              sat_w0;
    logic              y_step;
    seq_t              seq;
    logic [PC_W-1:0]   target;
  } ucode_t;

  localparam ucode_t UC_NOP = '{
    slot:   SLOT_GAIN,
    opnd:   OPND_H1,
    half:   HALF_LO,
    acc:    ACC_NONE,
    sat_w0: 1'b0,
    y_step: 1'b0,
    seq:    SEQ_NEXT,
    target: STEP_TOP
  };

  // one section per pass; a product is issued as low half then high half and
  // reaches the rounded product register through opnd_q, mul_reg and pp_lo
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t uc;
    uc = UC_NOP;
    case (pc)
      5'd0: begin
        uc.slot = SLOT_D1; uc.opnd = OPND_H1; uc.half = HALF_LO;
      end
      5'd1: begin
        uc.slot = SLOT_D1; uc.opnd = OPND_H1; uc.half = HALF_HI;
      end
      5'd2: begin
        uc.slot = SLOT_D2; uc.opnd = OPND_H2; uc.half = HALF_LO;
      end
      5'd3: begin
        uc.slot = SLOT_D2; uc.opnd = OPND_H2; uc.half = HALF_HI;
      end
      5'd4: begin
        uc.slot = SLOT_D3; uc.opnd = OPND_H3; uc.half = HALF_LO;
        uc.acc = ACC_LOADX;
      end
      5'd5: begin
        uc.slot = SLOT_D3; uc.opnd = OPND_H3; uc.half = HALF_HI;
      end
      5'd6: begin
        uc.slot = SLOT_D4; uc.opnd = OPND_H4; uc.half = HALF_LO;
        uc.acc = ACC_ADD;
      end
      5'd7: begin
        uc.slot = SLOT_D4; uc.opnd = OPND_H4; uc.half = HALF_HI;
      end
      5'd8: begin
        uc.acc = ACC_ADD;
      end
      5'd9: begin
        uc = UC_NOP;
      end
      5'd10: begin
        uc.acc = ACC_ADD;
      end
      5'd11: begin
        uc.sat_w0 = 1'b1;
      end
      5'd12: begin
        uc.slot = SLOT_GAIN; uc.opnd = OPND_T; uc.half = HALF_LO;
      end
      5'd13: begin
        uc.slot = SLOT_GAIN; uc.opnd = OPND_T; uc.half = HALF_HI;
      end
      5'd14: begin
        uc = UC_NOP;
      end
      5'd15: begin
        uc = UC_NOP;
      end
      5'd16: begin
        uc.y_step = 1'b1; uc.seq = SEQ_LOOP; uc.target = STEP_TOP;
      end
      5'd17: begin
        uc.seq = SEQ_END;
      end
      default: begin
        uc.seq = SEQ_END;
      end
    endcase
    return uc;
  endfunction

  // clip a wide sum to the signed history range
  function automatic logic signed [HIST_W-1:0] sat_hist(input logic signed [ACC_W-1:0] v);
    logic ovf;
    ovf = (v[ACC_W-1:HIST_W-1] != {(ACC_W-HIST_W+1){v[ACC_W-1]}});
    if (!ovf) begin
      return v[HIST_W-1:0];
    end else if (v[ACC_W-1]) begin
      return {1'b1, {(HIST_W-1){1'b0}}};
    end else begin
      return {1'b0, {(HIST_W-1){1'b1}}};
    end
  endfunction

  function automatic logic hist_clip(input logic signed [ACC_W-1:0] v);
    return (v[ACC_W-1:HIST_W-1] != {(ACC_W-HIST_W+1){v[ACC_W-1]}});
  endfunction

endpackage

// ----- src/butterworth_bandpass_cascade.sv -----
// Butterworth bandpass filter: a cascade of SECTIONS fourth-order sections, driven by a
// small control program over one shared multiplier. A sample transfer (tuser low)
// yields one result; its delay is set by the single multiplier, which forms each of the five
// products of a section from two 22-bit operand halves, plus the pipeline fill of each
// section. The next item is taken while a finished result still waits on the output.
// A coefficient transfer (tuser high) yields no result and clears all history;
// history also clears after a sample marked with tlast.
// Coefficients read as zero until written. Depends on bbc_pkg.
module butterworth_bandpass_cascade #(
  parameter int SECTIONS     = 4,
  parameter int SAMPLE_WIDTH = 16,
  parameter int COEF_WIDTH   = 24
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // sample, section[2], slot[3], coef_value, zero fill to bytes
  input  logic [((SAMPLE_WIDTH+COEF_WIDTH+5+7)/8)*8-1:0] s_axis_tdata,
  // kind
  input  logic s_axis_tuser,
  input  logic s_axis_tlast,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // filtered, zero fill to bytes
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  // saturated
  output logic m_axis_tuser,
  output logic m_axis_tlast
);

  localparam int M_DATA_W   = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int F_SECTION  = SAMPLE_WIDTH;
  localparam int F_SLOT     = F_SECTION + bbc_pkg::SECTION_W;
  localparam int F_COEF     = F_SLOT + bbc_pkg::SLOT_W;
  localparam int COEF_FRAC  = COEF_WIDTH - 4;
  localparam int COEF_DEPTH = SECTIONS * bbc_pkg::NSLOTS;
  localparam int CA_W       = $clog2(COEF_DEPTH);
  localparam int SEC_W      = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam int MUL_W      = COEF_WIDTH + bbc_pkg::OPND_HALF_W;
  localparam int FULL_W     = MUL_W + bbc_pkg::HALF_W;
  localparam int SHIFT      = bbc_pkg::HIST_FRAC - SAMPLE_WIDTH + 1;
  localparam int SHL        = (SHIFT > 0) ? SHIFT : 0;
  localparam int SHR        = (SHIFT < 0) ? -SHIFT : 0;
  localparam int CONV_W     = bbc_pkg::HIST_W + 8;
  localparam logic signed [CONV_W-1:0] OUT_MAX =
    {{(CONV_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [CONV_W-1:0] OUT_MIN = ~OUT_MAX;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t state;
  logic [bbc_pkg::PC_W-1:0] pc;
  logic [SEC_W-1:0] sec;
  bbc_pkg::ucode_t cw;

  logic signed [SAMPLE_WIDTH-1:0] in_sample;
  logic [bbc_pkg::SECTION_W-1:0] in_section;
  logic [bbc_pkg::SLOT_W-1:0] in_slot;
  logic signed [COEF_WIDTH-1:0] in_coef;
  logic in_xfer;
  logic coef_wr;
  logic [CA_W-1:0] wr_addr;
  logic [CA_W-1:0] rd_addr;

  logic signed [COEF_WIDTH-1:0] coef_mem [COEF_DEPTH];
  logic [COEF_DEPTH-1:0] coef_vld;
  logic signed [COEF_WIDTH-1:0] coef_q;
  logic vld_q;
  logic signed [COEF_WIDTH-1:0] coef_eff;

  logic signed [bbc_pkg::HIST_W-1:0] hist_one   [SECTIONS];
  logic signed [bbc_pkg::HIST_W-1:0] hist_two   [SECTIONS];
  logic signed [bbc_pkg::HIST_W-1:0] hist_three [SECTIONS];
  logic signed [bbc_pkg::HIST_W-1:0] hist_four  [SECTIONS];

  logic signed [bbc_pkg::OPND_W-1:0] opnd_full;
  logic signed [bbc_pkg::OPND_HALF_W-1:0] opnd_half;
  logic signed [bbc_pkg::OPND_HALF_W-1:0] opnd_q;
  logic signed [MUL_W-1:0] mul_full;
  logic signed [MUL_W-1:0] mul_reg;
  logic signed [MUL_W-1:0] pp_lo;
  logic signed [FULL_W-1:0] prod_full;
  logic signed [bbc_pkg::PROD_W-1:0] prod_reg;
  logic signed [bbc_pkg::ACC_W-1:0] acc;
  logic signed [bbc_pkg::OPND_W-1:0] u_reg;
  logic signed [bbc_pkg::HIST_W-1:0] w0_reg;
  logic signed [bbc_pkg::HIST_W-1:0] w0_sat;
  logic signed [bbc_pkg::HIST_W-1:0] y_sat;
  logic signed [bbc_pkg::OPND_W-1:0] t_reg;
  logic signed [bbc_pkg::HIST_W-1:0] x_reg;
  logic signed [bbc_pkg::HIST_W-1:0] x_in;
  logic signed [CONV_W-1:0] ox;
  logic out_ovf;
  logic [SAMPLE_WIDTH-1:0] out_val;
  logic last_reg;
  logic clip;
  logic last_sec;
  logic out_free;

  logic out_valid;
  logic [SAMPLE_WIDTH-1:0] out_data;
  logic out_last;
  logic out_sat;

  assign in_sample  = s_axis_tdata[SAMPLE_WIDTH-1:0];
  assign in_section = s_axis_tdata[F_SLOT-1:F_SECTION];
  assign in_slot    = s_axis_tdata[F_COEF-1:F_SLOT];
  assign in_coef    = s_axis_tdata[F_COEF+COEF_WIDTH-1:F_COEF];

  assign s_axis_tready = (state == ST_IDLE);
  assign in_xfer = s_axis_tvalid && s_axis_tready;
  assign coef_wr = in_xfer && (s_axis_tuser == bbc_pkg::KIND_COEF)
                   && (32'(in_section) < SECTIONS)
                   && (in_slot < bbc_pkg::SLOT_W'(bbc_pkg::NSLOTS));
  assign wr_addr = CA_W'(in_section) * CA_W'(bbc_pkg::NSLOTS) + CA_W'(in_slot);

  assign cw = bbc_pkg::ucode_rom(pc);
  assign rd_addr = CA_W'(sec) * CA_W'(bbc_pkg::NSLOTS) + CA_W'(cw.slot);
  assign last_sec = (sec == SEC_W'(SECTIONS - 1));
  assign out_free = !out_valid || m_axis_tready;

  // input scaling to the history format
  generate
    if (SHIFT >= 0) begin : g_in_left
      assign x_in = bbc_pkg::HIST_W'(in_sample) <<< SHL;
    end else begin : g_in_right
      localparam int RND_IN = 1 << (SHR - 1);
      logic signed [SAMPLE_WIDTH:0] x_rnd;
      assign x_rnd = (SAMPLE_WIDTH+1)'(in_sample) + (SAMPLE_WIDTH+1)'(RND_IN);
      assign x_in = bbc_pkg::HIST_W'(x_rnd >>> SHR);
    end
  endgenerate

  // output scaling back to the sample format
  generate
    if (SHIFT > 0) begin : g_out_right
      logic signed [bbc_pkg::HIST_W:0] x_rnd;
      assign x_rnd = (bbc_pkg::HIST_W+1)'(x_reg)
                     + ((bbc_pkg::HIST_W+1)'(1) <<< (SHL - 1));
      assign ox = CONV_W'(x_rnd >>> SHL);
    end else begin : g_out_left
      assign ox = CONV_W'(x_reg) <<< SHR;
    end
  endgenerate

  assign out_ovf = (ox > OUT_MAX) || (ox < OUT_MIN);
  assign out_val = !out_ovf ? ox[SAMPLE_WIDTH-1:0] :
                   (ox[CONV_W-1] ? OUT_MIN[SAMPLE_WIDTH-1:0] : OUT_MAX[SAMPLE_WIDTH-1:0]);

  always_comb begin
    case (cw.opnd)
      bbc_pkg::OPND_H1: opnd_full = bbc_pkg::OPND_W'(hist_one[sec]);
      bbc_pkg::OPND_H2: opnd_full = bbc_pkg::OPND_W'(hist_two[sec]);
      bbc_pkg::OPND_H3: opnd_full = bbc_pkg::OPND_W'(hist_three[sec]);
      bbc_pkg::OPND_H4: opnd_full = bbc_pkg::OPND_W'(hist_four[sec]);
      bbc_pkg::OPND_T:  opnd_full = t_reg;
      default:          opnd_full = '0;
    endcase
  end

  assign opnd_half = (cw.half == bbc_pkg::HALF_LO)
    ? $signed({1'b0, opnd_full[bbc_pkg::HALF_W-1:0]})
    : $signed({opnd_full[bbc_pkg::OPND_W-1], opnd_full[bbc_pkg::OPND_W-1:bbc_pkg::HALF_W]});

  assign coef_eff = vld_q ? coef_q : '0;
  assign mul_full = coef_eff * opnd_q;

  // high partial product in mul_reg, the earlier low one in pp_lo; round half up
  assign prod_full = (FULL_W'(mul_reg) <<< bbc_pkg::HALF_W) + FULL_W'(pp_lo)
                     + (FULL_W'(1) <<< (COEF_FRAC - 1));

  assign w0_sat = bbc_pkg::sat_hist(acc);
  assign y_sat  = bbc_pkg::sat_hist(prod_reg);

  // coefficient store
  always_ff @(posedge clk) begin
    if (coef_wr) begin
      coef_mem[wr_addr] <= in_coef;
    end
    coef_q <= coef_mem[rd_addr];
  end

  // datapath registers
  always_ff @(posedge clk) begin
    vld_q    <= coef_vld[rd_addr];
    opnd_q   <= opnd_half;
    mul_reg  <= mul_full;
    pp_lo    <= mul_reg;
    prod_reg <= prod_full[FULL_W-1:COEF_FRAC];
    u_reg    <= bbc_pkg::OPND_W'(hist_four[sec])
                - (bbc_pkg::OPND_W'(hist_two[sec]) <<< 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pc        <= bbc_pkg::STEP_TOP;
      sec       <= '0;
      out_valid <= 1'b0;
      coef_vld  <= '0;
      for (int i = 0; i < SECTIONS; i++) begin
        hist_one[i]   <= '0;
        hist_two[i]   <= '0;
        hist_three[i] <= '0;
        hist_four[i]  <= '0;
      end
    end else begin
      if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            if (s_axis_tuser == bbc_pkg::KIND_COEF) begin
              if (coef_wr) begin
                coef_vld[wr_addr] <= 1'b1;
              end
              for (int i = 0; i < SECTIONS; i++) begin
                hist_one[i]   <= '0;
                hist_two[i]   <= '0;
                hist_three[i] <= '0;
                hist_four[i]  <= '0;
              end
            end else begin
              x_reg    <= x_in;
              last_reg <= s_axis_tlast;
              clip     <= 1'b0;
              sec      <= '0;
              pc       <= bbc_pkg::STEP_TOP;
              state    <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          case (cw.acc)
            bbc_pkg::ACC_LOADX: acc <= prod_reg + bbc_pkg::ACC_W'(x_reg);
            bbc_pkg::ACC_ADD:   acc <= acc + prod_reg;
            default:            acc <= acc;
          endcase
          if (cw.sat_w0) begin
            w0_reg <= w0_sat;
            t_reg  <= bbc_pkg::OPND_W'(w0_sat) + u_reg;
            if (bbc_pkg::hist_clip(acc)) begin
              clip <= 1'b1;
            end
          end
          if (cw.y_step) begin
            x_reg <= y_sat;
            if (bbc_pkg::hist_clip(prod_reg)) begin
              clip <= 1'b1;
            end
            hist_four[sec]  <= hist_three[sec];
            hist_three[sec] <= hist_two[sec];
            hist_two[sec]   <= hist_one[sec];
            hist_one[sec]   <= w0_reg;
          end
          case (cw.seq)
            bbc_pkg::SEQ_NEXT: begin
              pc <= pc + 1'b1;
            end
            bbc_pkg::SEQ_LOOP: begin
              if (last_sec) begin
                pc <= pc + 1'b1;
              end else begin
                pc  <= cw.target;
                sec <= sec + 1'b1;
              end
            end
            bbc_pkg::SEQ_END: begin
              if (out_free) begin
                out_valid <= 1'b1;
                out_data  <= out_val;
                out_last  <= last_reg;
                out_sat   <= clip || out_ovf;
                pc        <= bbc_pkg::STEP_TOP;
                state     <= ST_IDLE;
                if (last_reg) begin
                  for (int i = 0; i < SECTIONS; i++) begin
                    hist_one[i]   <= '0;
                    hist_two[i]   <= '0;
                    hist_three[i] <= '0;
                    hist_four[i]  <= '0;
                  end
                end
              end
            end
            default: begin
              pc <= pc;
            end
          endcase
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = M_DATA_W'(out_data);
  assign m_axis_tlast  = out_last;
  assign m_axis_tuser  = out_sat;

endmodule

// ----- verif/tb_butterworth_bandpass_cascade.sv -----
// self-checking testbench for butterworth_bandpass_cascade: directed corner cases, then
// random sample blocks and coefficient writes checked against a fixed-point filter model
// depends on bbc_pkg and butterworth_bandpass_cascade
`timescale 1ns / 100ps

module tb_butterworth_bandpass_cascade;
  import bbc_pkg::*;

  localparam int SECTIONS    = 4;
  localparam int SAMPLE_W    = 16;
  localparam int COEF_W      = 24;
  localparam int COEF_FRAC   = COEF_W - 4;
  localparam int SAMPLE_FRAC = SAMPLE_W - 1;
  localparam int OUT_SHIFT   = HIST_FRAC - SAMPLE_FRAC;
  localparam int TDATA_W     = ((SAMPLE_W + COEF_W + 5 + 7) / 8) * 8;
  localparam int ITEM_TARGET = 1450;
  localparam int DRAIN_WAIT  = 100;

  localparam logic [SLOT_W-1:0] SLOT_SPARE_LO = 3'd5;
  localparam logic [SLOT_W-1:0] SLOT_SPARE_HI = 3'd7;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] filtered;
    logic                       last;
    logic                       sat;
  } filt_result_t;

  logic                clk;
  logic                rst;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [TDATA_W-1:0]  s_axis_tdata;
  logic                s_axis_tuser;
  logic                s_axis_tlast;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [SAMPLE_W-1:0] m_axis_tdata;
  logic                m_axis_tuser;
  logic                m_axis_tlast;

  // coefficient table and per-section history of the filter model
  logic signed [COEF_W-1:0] coef_mem [SECTIONS][NSLOTS];
  logic signed [HIST_W-1:0] w1_q [SECTIONS];
  logic signed [HIST_W-1:0] w2_q [SECTIONS];
  logic signed [HIST_W-1:0] w3_q [SECTIONS];
  logic signed [HIST_W-1:0] w4_q [SECTIONS];
  logic                     pred_clip;

  filt_result_t pending_q [$];
  filt_result_t got_res;
  filt_result_t want_res;

  bit gaps_on;
  int hold_req;
  int items_sent;
  int n_samples;
  int n_coef_writes;
  int n_results;
  int n_sat_results;
  int n_block_ends;
  int mismatches;

  butterworth_bandpass_cascade #(
    .SECTIONS    (SECTIONS),
    .SAMPLE_WIDTH(SAMPLE_W),
    .COEF_WIDTH  (COEF_W)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic signed [63:0] mul_q20(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [127:0] p;
    p = a * b;
    p = p + (128'sd1 <<< (COEF_FRAC - 1));
    return p[COEF_FRAC +: 64];
  endfunction

  function automatic logic signed [63:0] clip_to(input logic signed [63:0] v, input int w);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (w - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) begin
      pred_clip = 1'b1;
      return hi;
    end
    if (v < lo) begin
      pred_clip = 1'b1;
      return lo;
    end
    return v;
  endfunction

  function automatic void clear_history();
    for (int s = 0; s < SECTIONS; s++) begin
      w1_q[s] = '0;
      w2_q[s] = '0;
      w3_q[s] = '0;
      w4_q[s] = '0;
    end
  endfunction

  function automatic void filter_sample(input logic signed [SAMPLE_W-1:0] smp, input logic lst);
    logic signed [63:0] x;
    logic signed [63:0] w0;
    logic signed [63:0] y;
    filt_result_t r;
    pred_clip = 1'b0;
    x = smp;
    x = x <<< OUT_SHIFT;
    for (int s = 0; s < SECTIONS; s++) begin
      w0 = mul_q20(coef_mem[s][SLOT_D1], w1_q[s]) + mul_q20(coef_mem[s][SLOT_D2], w2_q[s])
         + mul_q20(coef_mem[s][SLOT_D3], w3_q[s]) + mul_q20(coef_mem[s][SLOT_D4], w4_q[s]) + x;
      w0 = clip_to(w0, HIST_W);
      y = mul_q20(coef_mem[s][SLOT_GAIN], w0 - w2_q[s] - w2_q[s] + w4_q[s]);
      y = clip_to(y, HIST_W);
      w4_q[s] = w3_q[s];
      w3_q[s] = w2_q[s];
      w2_q[s] = w1_q[s];
      w1_q[s] = w0[HIST_W-1:0];
      x = y;
    end
    x = (x + (64'sd1 <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
    x = clip_to(x, SAMPLE_W);
    r.filtered = x[SAMPLE_W-1:0];
    r.last = lst;
    r.sat = pred_clip;
    pending_q.push_back(r);
    if (lst) clear_history();
  endfunction

  task automatic report_mismatch(input string what, input longint want, input longint got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch at %0t: %s expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  // one input transfer, with a random gap ahead of it when idling is on
  task automatic send_item(input logic kind, input logic signed [SAMPLE_W-1:0] smp,
                           input logic lst, input logic [SECTION_W-1:0] sec,
                           input logic [SLOT_W-1:0] slt, input logic signed [COEF_W-1:0] cv);
    int gap;
    gap = gaps_on ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tlast  <= lst;
    s_axis_tdata  <= {{(TDATA_W - SAMPLE_W - COEF_W - 5){1'b0}}, cv, slt, sec, smp};
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
    if (kind == KIND_COEF) begin
      n_coef_writes++;
      if (slt < NSLOTS) coef_mem[sec][slt] = cv;
      clear_history();
    end else begin
      n_samples++;
      filter_sample(smp, lst);
    end
  endtask

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp, input logic lst);
    send_item(KIND_SAMPLE, smp, lst, '0, SLOT_GAIN, '0);
  endtask

  task automatic write_coef(input logic [SECTION_W-1:0] sec, input logic [SLOT_W-1:0] slt,
                            input logic signed [COEF_W-1:0] cv);
    send_item(KIND_COEF, '0, 1'b0, sec, slt, cv);
  endtask

  task automatic wait_results_done();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_q.size() != 0);
  endtask

  // stable bandpass design, poles at radius 0.9, with optional jitter per coefficient
  task automatic load_design(input bit jitter);
    logic signed [COEF_W-1:0] cv;
    int j;
    for (int s = 0; s < SECTIONS; s++) begin
      for (int k = 0; k < NSLOTS; k++) begin
        case (k)
          0:       cv = 24'sd52429;
          1:       cv = 24'sd2642412;
          2:       cv = -24'sd3329439;
          3:       cv = 24'sd2140353;
          default: cv = -24'sd687972;
        endcase
        j = jitter ? int'($urandom_range(0, 8191)) - 4096 : 0;
        write_coef(SECTION_W'(s), SLOT_W'(k), cv + j);
      end
    end
  endtask

  task automatic send_block(input int len, input int shift);
    logic [SAMPLE_W-1:0] raw;
    logic signed [SAMPLE_W-1:0] smp;
    for (int i = 0; i < len; i++) begin
      raw = SAMPLE_W'($urandom);
      smp = $signed(raw) >>> shift;
      send_sample(smp, i == len - 1);
    end
  endtask

  task automatic test_unwritten_coefs();
    send_sample(16'sh7fff, 1'b0);
    send_sample(-16'sh8000, 1'b0);
    send_sample(16'sh0000, 1'b1);
  endtask

  task automatic test_ignored_writes();
    write_coef(2'd3, SLOT_SPARE_LO, 24'sh7fffff);
    write_coef(2'd0, SLOT_SPARE_HI, -24'sh800000);
    send_sample(16'sh7fff, 1'b1);
  endtask

  task automatic test_saturation();
    for (int s = 0; s < SECTIONS; s++) write_coef(SECTION_W'(s), SLOT_GAIN, 24'sh7fffff);
    write_coef(2'd0, SLOT_D1, -24'sh800000);
    for (int i = 0; i < 8; i++) send_sample(i[0] ? -16'sh8000 : 16'sh7fff, i == 7);
  endtask

  task automatic test_write_clears_history();
    send_sample(16'sh7fff, 1'b0);
    write_coef(2'd1, SLOT_D4, 24'sd0);
    send_sample(16'sh0001, 1'b1);
  endtask

  task automatic test_output_hold();
    gaps_on = 1'b0;
    hold_req = 600;
    send_block(8, 2);
    gaps_on = 1'b1;
  endtask

  task automatic test_drain_pause();
    send_block(5, 3);
    wait_results_done();
    send_block(5, 0);
  endtask

  task automatic test_random_traffic();
    int pick;
    logic [SAMPLE_W-1:0] raw;
    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      gaps_on = ($urandom_range(0, 3) != 0);
      if (pick < 8) begin
        write_coef(SECTION_W'($urandom), SLOT_W'($urandom), COEF_W'($urandom));
      end else if (pick < 12) begin
        load_design(1'b1);
      end else if (pick < 18) begin
        repeat ($urandom_range(1, 4)) begin
          raw = SAMPLE_W'($urandom);
          send_sample(raw, $urandom_range(0, 1));
        end
      end else begin
        send_block($urandom_range(1, 24), $urandom_range(0, 8));
      end
    end
    gaps_on = 1'b1;
  endtask

  // receiver: random stalls per result, plus one long hold on request
  initial begin : rx_side
    int n;
    m_axis_tready = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_req > 0) begin
        n = hold_req;
        hold_req = 0;
      end else begin
        n = gaps_on ? $urandom_range(0, 13) : 0;
      end
      if (n > 0) begin
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_res.filtered = m_axis_tdata;
      got_res.last = m_axis_tlast;
      got_res.sat = m_axis_tuser;
      n_results++;
      if (got_res.sat) n_sat_results++;
      if (got_res.last) n_block_ends++;
      if (pending_q.size() == 0) begin
        report_mismatch("unrequested result, filtered", 0, got_res.filtered);
      end else begin
        want_res = pending_q.pop_front();
        if (got_res.filtered !== want_res.filtered)
          report_mismatch("filtered", want_res.filtered, got_res.filtered);
        if (got_res.last !== want_res.last)
          report_mismatch("last", want_res.last, got_res.last);
        if (got_res.sat !== want_res.sat)
          report_mismatch("saturated", want_res.sat, got_res.sat);
      end
    end
  end

  initial begin
    #3000000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = KIND_SAMPLE;
    s_axis_tlast = 1'b0;
    gaps_on = 1'b1;
    hold_req = 0;
    items_sent = 0;
    n_samples = 0;
    n_coef_writes = 0;
    n_results = 0;
    n_sat_results = 0;
    n_block_ends = 0;
    mismatches = 0;
    for (int s = 0; s < SECTIONS; s++) begin
      for (int k = 0; k < NSLOTS; k++) coef_mem[s][k] = '0;
    end
    clear_history();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_unwritten_coefs();
    test_ignored_writes();
    test_saturation();
    test_write_clears_history();
    load_design(1'b0);
    test_output_hold();
    test_drain_pause();
    test_random_traffic();

    wait_results_done();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (pending_q.size() != 0) report_mismatch("results missing", 0, pending_q.size());
    $display("covered %0d samples and %0d coefficient writes; %0d results checked",
             n_samples, n_coef_writes, n_results);
    $display("%0d results clipped, %0d blocks closed by tlast, %0d mismatches",
             n_sat_results, n_block_ends, mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
